[hw/rtl/fcte_pkg.sv]
// Shared types and constants for the file allocation table chain engine.
`timescale 1ns / 1ps

package fcte_pkg;

   localparam int DEF_MAX_BLOCKS = 8192;
   localparam int BLK_W          = 16;
   localparam int AMT_W          = 16;
   localparam int DBC_W          = 14;

   localparam logic [DBC_W-1:0] DBC_RESET = 14'd8192;
   localparam logic [BLK_W-1:0] END_MARK  = 16'hFFFF;
   localparam logic [BLK_W-1:0] FREE_MARK = 16'h0000;

   typedef enum logic [2:0] {
      KIND_LOAD  = 3'd0,
      KIND_READ  = 3'd1,
      KIND_NEW   = 3'd2,
      KIND_EXT   = 3'd3,
      KIND_FREE  = 3'd4,
      KIND_WALK  = 3'd5,
      KIND_COUNT = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NO_FREE = 2'd1,
      STAT_NO_END  = 2'd2,
      STAT_RANGE   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_EV,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_WR_END,
      ST_WR_LINK,
      ST_WR_LOAD,
      ST_DONE
   } fcte_state_type;

endpackage

[hw/rtl/fat_chain_table_engine.sv]
// Top level of the file allocation table chain engine: sequencer and datapath.
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// request   req_kind, req_start_block,              taken when start=1 and busy=0
//           req_entry_value, req_step_count
// response  rsp_status, rsp_result_block,           one cycle, marked by rsp_valid
//           rsp_amount
// config    csr_wdata (data_block_count)            written when csr_we=1
//
// One request at a time; busy stays high through the response strobe.
// Each chain link and each scanned entry takes a read state, then an evaluate state,
// on the single table port; each added block of an extend adds an end-mark write
// and then a link write. Count free scans every entry below the usable count.
// Reset clears the sequencer and sets data_block_count to 8192; table contents are
// undefined until loaded. The response cannot be stalled.

module fat_chain_table_engine
   import fcte_pkg::*;
#(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [2:0]       req_kind,
   input  logic [BLK_W-1:0] req_start_block,
   input  logic [BLK_W-1:0] req_entry_value,
   input  logic [AMT_W-1:0] req_step_count,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [BLK_W-1:0] rsp_result_block,
   output logic [AMT_W-1:0] rsp_amount,
   input  logic             csr_we,
   input  logic [DBC_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_BLOCKS);
   localparam logic [BLK_W-1:0] MAX_N = BLK_W'(MAX_BLOCKS);

   fcte_state_type state_ff, state_in;

   logic [DBC_W-1:0] dbc_ff;
   logic [2:0]       kind_ff, kind_in;
   logic [BLK_W-1:0] cur_ff, cur_in;     // current chain block
   logic [BLK_W-1:0] ptr_ff, ptr_in;     // scan position / freshly found block
   logic [BLK_W-1:0] cnt_ff, cnt_in;     // links taken so far
   logic [AMT_W-1:0] sc_ff, sc_in;
   logic [BLK_W-1:0] ev_ff, ev_in;
   logic [1:0]       status_ff, status_in;
   logic [BLK_W-1:0] rb_ff, rb_in;
   logic [AMT_W-1:0] am_ff, am_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [BLK_W-1:0]  ram_wdata;
   logic [BLK_W-1:0]  ram_rdata;

   // usable count: data_block_count saturated to the table size
   logic [BLK_W-1:0] n_use;
   logic             n_zero;
   logic             accept;
   logic             sb_oor;
   logic             v_end, v_oor, v_zero;
   logic [BLK_W:0]   cnt_inc, ptr_inc, am_inc;
   logic             cnt_last_n, cnt_last_sc, ptr_last, am_last;

   assign n_use  = ({2'b00, dbc_ff} > MAX_N) ? MAX_N : {2'b00, dbc_ff};
   assign n_zero = (n_use == '0);
   assign accept = start && (state_ff == ST_IDLE);
   assign sb_oor = (req_start_block >= n_use);

   assign v_end  = (ram_rdata == END_MARK);
   assign v_oor  = (ram_rdata >= n_use);
   assign v_zero = (ram_rdata == FREE_MARK);

   assign cnt_inc = {1'b0, cnt_ff} + 17'd1;
   assign ptr_inc = {1'b0, ptr_ff} + 17'd1;
   assign am_inc  = {1'b0, am_ff} + 17'd1;

   assign cnt_last_n  = (cnt_inc >= {1'b0, n_use});
   assign cnt_last_sc = (cnt_inc >= {1'b0, sc_ff});
   assign ptr_last    = (ptr_inc >= {1'b0, n_use});
   assign am_last     = (am_inc >= {1'b0, sc_ff});

   fcte_ram #(
      .WIDTH (BLK_W),
      .DEPTH (MAX_BLOCKS),
      .ADDR_W(ADDR_W)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_LOAD:  state_in = sb_oor ? ST_DONE : ST_WR_LOAD;
                  KIND_READ,
                  KIND_EXT,
                  KIND_FREE:  state_in = sb_oor ? ST_DONE : ST_WALK_RD;
                  KIND_WALK:  state_in = (sb_oor || req_step_count == '0) ? ST_DONE
                                                                          : ST_WALK_RD;
                  KIND_NEW,
                  KIND_COUNT: state_in = n_zero ? ST_DONE : ST_SCAN_RD;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK_RD: state_in = ST_WALK_EV;
         ST_WALK_EV: begin
            case (kind_ff)
               KIND_EXT: begin
                  if (v_end) begin
                     state_in = (sc_ff == '0) ? ST_DONE : ST_SCAN_RD;
                  end else if (v_oor || cnt_last_n) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_WALK_RD;
                  end
               end
               KIND_FREE: begin
                  state_in = (v_end || v_oor || cnt_last_n) ? ST_DONE : ST_WALK_RD;
               end
               KIND_WALK: begin
                  state_in = (v_end || v_oor || cnt_last_sc || cnt_last_n) ? ST_DONE
                                                                           : ST_WALK_RD;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SCAN_RD: state_in = ST_SCAN_EV;
         ST_SCAN_EV: begin
            if (kind_ff inside {KIND_NEW, KIND_EXT} && v_zero) begin
               state_in = ST_WR_END;
            end else if (ptr_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_WR_END:  state_in = (kind_ff == KIND_EXT) ? ST_WR_LINK : ST_DONE;
         ST_WR_LINK: state_in = (am_last || ptr_last) ? ST_DONE : ST_SCAN_RD;
         ST_WR_LOAD: state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath and table port
   always_comb begin
      kind_in   = kind_ff;
      cur_in    = cur_ff;
      ptr_in    = ptr_ff;
      cnt_in    = cnt_ff;
      sc_in     = sc_ff;
      ev_in     = ev_ff;
      status_in = status_ff;
      rb_in     = rb_ff;
      am_in     = am_ff;
      ram_we    = 1'b0;
      ram_addr  = cur_ff[ADDR_W-1:0];
      ram_wdata = FREE_MARK;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // capture the request and clear the result
               kind_in   = req_kind;
               cur_in    = req_start_block;
               ptr_in    = '0;
               cnt_in    = '0;
               sc_in     = req_step_count;
               ev_in     = req_entry_value;
               am_in     = '0;
               rb_in     = '0;
               status_in = STAT_OK;
               if (sb_oor && req_kind inside {KIND_LOAD, KIND_READ, KIND_EXT,
                                              KIND_FREE, KIND_WALK}) begin
                  status_in = STAT_RANGE;
               end else if (req_kind == KIND_NEW && n_zero) begin
                  status_in = STAT_NO_FREE;
               end else if (req_kind == KIND_WALK) begin
                  rb_in = req_start_block;
               end
            end
         end
         ST_SCAN_RD: begin
            ram_addr = ptr_ff[ADDR_W-1:0];
         end
         ST_WALK_EV: begin
            case (kind_ff)
               KIND_READ: begin
                  am_in = ram_rdata;
               end
               KIND_EXT: begin
                  if (v_end) begin
                     rb_in  = cur_ff;
                     ptr_in = '0;
                  end else if (v_oor) begin
                     status_in = STAT_RANGE;
                     rb_in     = cur_ff;
                  end else begin
                     cur_in = ram_rdata;
                     cnt_in = cnt_inc[BLK_W-1:0];
                     if (cnt_last_n) begin
                        status_in = STAT_NO_END;
                        rb_in     = ram_rdata;
                     end
                  end
               end
               KIND_FREE: begin
                  // clear the link just read
                  ram_we    = 1'b1;
                  ram_wdata = FREE_MARK;
                  am_in     = am_inc[AMT_W-1:0];
                  if (v_end) begin
                     rb_in = '0;
                  end else if (v_oor) begin
                     status_in = STAT_RANGE;
                     rb_in     = cur_ff;
                  end else begin
                     cur_in = ram_rdata;
                     cnt_in = cnt_inc[BLK_W-1:0];
                     if (cnt_last_n) begin
                        status_in = STAT_NO_END;
                     end
                  end
               end
               KIND_WALK: begin
                  if (v_end) begin
                     status_in = STAT_NO_END;
                     rb_in     = cur_ff;
                  end else if (v_oor) begin
                     status_in = STAT_RANGE;
                     rb_in     = cur_ff;
                  end else begin
                     cur_in = ram_rdata;
                     am_in  = am_inc[AMT_W-1:0];
                     cnt_in = cnt_inc[BLK_W-1:0];
                     rb_in  = ram_rdata;
                     if (!cnt_last_sc && cnt_last_n) begin
                        status_in = STAT_NO_END;
                     end
                  end
               end
               default: begin
                  am_in = am_ff;
               end
            endcase
         end
         ST_SCAN_EV: begin
            case (kind_ff)
               KIND_NEW: begin
                  if (v_zero) begin
                     rb_in = ptr_ff;
                  end else begin
                     ptr_in = ptr_inc[BLK_W-1:0];
                     if (ptr_last) begin
                        status_in = STAT_NO_FREE;
                     end
                  end
               end
               KIND_EXT: begin
                  // on a hit, hold ptr: it names the block to append
                  if (!v_zero) begin
                     ptr_in = ptr_inc[BLK_W-1:0];
                     if (ptr_last) begin
                        status_in = STAT_NO_FREE;
                        rb_in     = cur_ff;
                     end
                  end
               end
               KIND_COUNT: begin
                  if (v_zero) begin
                     am_in = am_inc[AMT_W-1:0];
                  end
                  ptr_in = ptr_inc[BLK_W-1:0];
               end
               default: begin
                  ptr_in = ptr_ff;
               end
            endcase
         end
         ST_WR_END: begin
            ram_we    = 1'b1;
            ram_addr  = ptr_ff[ADDR_W-1:0];
            ram_wdata = END_MARK;
         end
         ST_WR_LINK: begin
            // hook the new block behind the old tail and advance;
            // entries below the found block stay in use, so resume after it
            ram_we    = 1'b1;
            ram_wdata = ptr_ff;
            cur_in    = ptr_ff;
            rb_in     = ptr_ff;
            am_in     = am_inc[AMT_W-1:0];
            ptr_in    = ptr_inc[BLK_W-1:0];
            if (!am_last && ptr_last) begin
               status_in = STAT_NO_FREE;
            end
         end
         ST_WR_LOAD: begin
            ram_we    = 1'b1;
            ram_wdata = ev_ff;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dbc_ff   <= DBC_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            dbc_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      cur_ff    <= cur_in;
      ptr_ff    <= ptr_in;
      cnt_ff    <= cnt_in;
      sc_ff     <= sc_in;
      ev_ff     <= ev_in;
      status_ff <= status_in;
      rb_ff     <= rb_in;
      am_ff     <= am_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_status       = status_ff;
   assign rsp_result_block = rb_ff;
   assign rsp_amount       = am_ff;

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request accepted but engine not busy");

   a_link_after_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR_LINK) |-> $past(state_ff == ST_WR_END))
      else $error("link write without end mark write");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_RD) |-> (cur_ff < n_use))
      else $error("chain read outside usable table");
`endif

endmodule

[hw/rtl/fcte_ram.sv]
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module fcte_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
